[hdl/in_order_output_reorder_buffer_assert.svh]
// Assertion macros of the reorder buffer's top module.
`ifndef IN_ORDER_OUTPUT_REORDER_BUFFER_ASSERT_SVH
`define IN_ORDER_OUTPUT_REORDER_BUFFER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define IOROB_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define IOROB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/iorob_pkg.sv]
// Shared types, codes and defaults of the in-order reorder buffer.
package iorob_pkg;

	// Operation codes of a request
	localparam logic [1:0] OP_BEGIN  = 2'd0;
	localparam logic [1:0] OP_FINISH = 2'd1;
	localparam logic [1:0] OP_FLUSH  = 2'd2;

	// Result status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_DUP   = 2'd2;
	localparam logic [1:0] ST_FULL  = 2'd3;

	// Configuration register indexes
	localparam logic CFG_REORDER_ENABLE  = 1'b0;
	localparam logic CFG_FLUSH_THRESHOLD = 1'b1;

	localparam int THR_W      = 6;
	localparam int CFG_DATA_W = 6;
	localparam logic             REORDER_RESET = 1'b1;
	localparam logic [THR_W-1:0] THR_RESET     = 6'd16;

	// Most records one flush may release
	localparam int MAX_OUT = 32;
	localparam int NCNT_W  = $clog2(MAX_OUT);

	// Defaults of the top-level parameters
	localparam int WINDOW_DEPTH_DEF = 32;
	localparam int FIFO_DEPTH_DEF   = 32;
	localparam int HANDLE_BITS_DEF  = 32;

	typedef struct packed {
		logic [1:0]  operation;
		logic [31:0] read_id;
		logic [31:0] record_handle;
		logic        force_flush;
	} req_item_t;

	typedef struct packed {
		logic        has_record;
		logic [31:0] record_out;
		logic [31:0] record_id;
		logic        last;
		logic [1:0]  status;
		logic [31:0] started_total;
		logic [31:0] finished_total;
		logic [31:0] flushed_total;
	} rsp_item_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic do_op;
		logic flush_start;
		logic scan_step;
		logic emit_rec;
		logic emit_empty;
		logic last;
	} cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic scan_pass;
		logic scan_fail;
		logic avail;
		logic avail_next;
	} sts_t;

endpackage

[hdl/iorob_req_if.sv]
// Request channel: valid, ready and one request item.
interface iorob_req_if
	import iorob_pkg::*;
();
	logic      valid;
	logic      ready;
	req_item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

[hdl/iorob_rsp_if.sv]
// Result channel: valid, ready and one result item.
interface iorob_rsp_if
	import iorob_pkg::*;
();
	logic      valid;
	logic      ready;
	rsp_item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

[hdl/iorob_ctrl.sv]
// Controller state machine of the reorder buffer: accept, scan, release.
module iorob_ctrl
	import iorob_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [1:0] in_op,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  sts_t       st,
	output cmd_t       cmd
);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_SCAN  = 2'd1;
	localparam logic [1:0] S_EMIT  = 2'd2;
	localparam logic [1:0] S_EMPTY = 2'd3;

	logic [1:0]        state_q, state_d;
	logic [NCNT_W-1:0] n_q;
	logic              out_valid_q;
	logic              out_free;
	logic              accept;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE) && out_free;
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;

	// Sequence one request: single result, or scan then release run
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (in_op == OP_FLUSH) begin
						cmd.flush_start = 1'b1;
						state_d         = S_SCAN;
					end else begin
						cmd.do_op = 1'b1;
					end
				end
			end
			S_SCAN: begin
				if (st.scan_pass) begin
					state_d = S_EMIT;
				end else if (st.scan_fail) begin
					state_d = S_EMPTY;
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			S_EMIT: begin
				if (out_free) begin
					if (st.avail) begin
						cmd.emit_rec = 1'b1;
						cmd.last     = !st.avail_next || (n_q == NCNT_W'(MAX_OUT - 1));
						if (cmd.last) begin
							state_d = S_IDLE;
						end
					end else begin
						cmd.emit_empty = 1'b1;
						state_d        = S_IDLE;
					end
				end
			end
			S_EMPTY: begin
				if (out_free) begin
					cmd.emit_empty = 1'b1;
					state_d        = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Hold state, release count and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			n_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.flush_start) begin
				n_q <= '0;
			end else if (cmd.emit_rec) begin
				n_q <= n_q + 1'b1;
			end
			if (cmd.do_op || cmd.emit_rec || cmd.emit_empty) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

[hdl/iorob_dp.sv]
// Datapath of the reorder buffer: window marks, record store, FIFO, counters.
module iorob_dp
	import iorob_pkg::*;
#(
	parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
	parameter int FIFO_DEPTH   = FIFO_DEPTH_DEF,
	parameter int HANDLE_BITS  = HANDLE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic                  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  req_item_t             in_item,
	input  cmd_t                  cmd,
	output sts_t                  st,
	output rsp_item_t             out_item
);

	localparam int WIN_W = $clog2(WINDOW_DEPTH);
	localparam int RUN_W = $clog2(WINDOW_DEPTH + 1);
	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
	localparam int CMP_W = (RUN_W > THR_W) ? RUN_W : THR_W;
	localparam int KEEP  = (HANDLE_BITS < 32) ? HANDLE_BITS : 32;
	localparam int ENT_W = HANDLE_BITS + 32;

	// Configuration
	logic             reorder_q;
	logic [THR_W-1:0] thr_q;

	// Window state
	logic [31:0]             base_q;
	logic [WIN_W-1:0]        head_q, head_next;
	logic [WINDOW_DEPTH-1:0] started_q, finished_q;
	logic [HANDLE_BITS-1:0]  rec_mem [WINDOW_DEPTH];
	logic [HANDLE_BITS-1:0]  rec_rdata_q;
	logic [WIN_W-1:0]        rec_raddr;

	// Pass-through FIFO state
	logic [ENT_W-1:0] fifo_mem [FIFO_DEPTH];
	logic [ENT_W-1:0] fifo_rdata_q;
	logic [PTR_W-1:0] rd_q, wr_q, rd_next, wr_next, fifo_raddr;
	logic [CNT_W-1:0] cnt_q;

	// Counters and flush scan
	logic [31:0]      started_cnt_q, finished_cnt_q, flushed_cnt_q;
	logic [31:0]      started_cnt_d, finished_cnt_d, flushed_cnt_d;
	logic [RUN_W-1:0] run_q;
	logic [WIN_W-1:0] scan_q;
	logic             force_q;

	// Request decode
	logic [31:0]            offset;
	logic                   in_win;
	logic [WIN_W:0]         slot_sum;
	logic [WIN_W-1:0]       slot;
	logic [HANDLE_BITS-1:0] handle_in;
	logic                   is_begin, is_finish;
	logic                   begin_ok, begin_mark;
	logic                   fifo_full, fin_fifo, fin_win;
	logic                   rel_win, rel_fifo;
	logic [1:0]             status;

	assign handle_in = HANDLE_BITS'(in_item.record_handle[KEEP-1:0]);

	// Locate the request's slot in the ring
	assign offset   = in_item.read_id - base_q;
	assign in_win   = offset < 32'(WINDOW_DEPTH);
	assign slot_sum = {1'b0, head_q} + {1'b0, offset[WIN_W-1:0]};
	assign slot     = (slot_sum >= (WIN_W + 1)'(WINDOW_DEPTH))
		? WIN_W'(slot_sum - (WIN_W + 1)'(WINDOW_DEPTH)) : slot_sum[WIN_W-1:0];

	assign head_next = (head_q == WIN_W'(WINDOW_DEPTH - 1)) ? '0 : head_q + 1'b1;
	assign rd_next   = (rd_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_q + 1'b1;
	assign wr_next   = (wr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_q + 1'b1;

	assign is_begin   = cmd.do_op && (in_item.operation == OP_BEGIN);
	assign is_finish  = cmd.do_op && (in_item.operation == OP_FINISH);
	assign begin_ok   = is_begin && (!reorder_q || in_win);
	assign begin_mark = is_begin && reorder_q && in_win;
	assign fifo_full  = cnt_q == CNT_W'(FIFO_DEPTH);
	assign fin_fifo   = is_finish && !reorder_q && !fifo_full;
	assign fin_win    = is_finish && reorder_q && in_win && started_q[slot] && !finished_q[slot];
	assign rel_win    = cmd.emit_rec && reorder_q;
	assign rel_fifo   = cmd.emit_rec && !reorder_q;

	// Classify the outcome of a begin or finish
	always_comb begin
		status = ST_OK;
		case (in_item.operation)
			OP_BEGIN: begin
				if (reorder_q && !in_win) begin
					status = ST_RANGE;
				end
			end
			OP_FINISH: begin
				if (!reorder_q) begin
					status = fifo_full ? ST_FULL : ST_OK;
				end else if (!in_win) begin
					status = ST_RANGE;
				end else if (!started_q[slot] || finished_q[slot]) begin
					status = ST_DUP;
				end
			end
			default: begin
				status = ST_OK;
			end
		endcase
	end

	assign started_cnt_d  = started_cnt_q + 32'(begin_ok);
	assign finished_cnt_d = finished_cnt_q + 32'(fin_fifo || fin_win);
	assign flushed_cnt_d  = flushed_cnt_q + 32'(cmd.emit_rec);

	// Status for the controller
	assign st.scan_pass  = force_q || !reorder_q || (CMP_W'(run_q) >= CMP_W'(thr_q));
	assign st.scan_fail  = !st.scan_pass
		&& (!finished_q[scan_q] || (run_q == RUN_W'(WINDOW_DEPTH)));
	assign st.avail      = reorder_q ? finished_q[head_q] : (cnt_q != '0);
	assign st.avail_next = reorder_q ? finished_q[head_next] : (cnt_q != CNT_W'(1));

	// Read the next entry ahead while releasing
	assign rec_raddr  = rel_win ? head_next : head_q;
	assign fifo_raddr = rel_fifo ? rd_next : rd_q;

	// Control state: configuration, marks, pointers, counters, scan
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reorder_q      <= REORDER_RESET;
			thr_q          <= THR_RESET;
			base_q         <= '0;
			head_q         <= '0;
			started_q      <= '0;
			finished_q     <= '0;
			rd_q           <= '0;
			wr_q           <= '0;
			cnt_q          <= '0;
			started_cnt_q  <= '0;
			finished_cnt_q <= '0;
			flushed_cnt_q  <= '0;
			run_q          <= '0;
			scan_q         <= '0;
			force_q        <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_REORDER_ENABLE:  reorder_q <= cfg_data[0];
					CFG_FLUSH_THRESHOLD: thr_q     <= cfg_data[THR_W-1:0];
					default: begin
					end
				endcase
			end
			started_cnt_q  <= started_cnt_d;
			finished_cnt_q <= finished_cnt_d;
			flushed_cnt_q  <= flushed_cnt_d;
			if (begin_mark) begin
				started_q[slot]  <= 1'b1;
				finished_q[slot] <= 1'b0;
			end
			if (fin_win) begin
				finished_q[slot] <= 1'b1;
			end
			if (rel_win) begin
				started_q[head_q]  <= 1'b0;
				finished_q[head_q] <= 1'b0;
				head_q             <= head_next;
				base_q             <= base_q + 32'd1;
			end
			if (fin_fifo) begin
				wr_q  <= wr_next;
				cnt_q <= cnt_q + 1'b1;
			end
			if (rel_fifo) begin
				rd_q  <= rd_next;
				cnt_q <= cnt_q - 1'b1;
			end
			if (cmd.flush_start) begin
				run_q   <= '0;
				scan_q  <= head_q;
				force_q <= in_item.force_flush;
			end else if (cmd.scan_step) begin
				run_q  <= run_q + 1'b1;
				scan_q <= (scan_q == WIN_W'(WINDOW_DEPTH - 1)) ? '0 : scan_q + 1'b1;
			end
		end
	end

	// Record store and FIFO memories with registered reads
	always_ff @(posedge clk) begin
		if (fin_win) begin
			rec_mem[slot] <= handle_in;
		end
		rec_rdata_q <= rec_mem[rec_raddr];
		if (fin_fifo) begin
			fifo_mem[wr_q] <= {in_item.read_id, handle_in};
		end
		fifo_rdata_q <= fifo_mem[fifo_raddr];
	end

	// Load the result register
	always_ff @(posedge clk) begin
		if (cmd.do_op) begin
			out_item.has_record     <= 1'b0;
			out_item.record_out     <= '0;
			out_item.record_id      <= '0;
			out_item.last           <= 1'b1;
			out_item.status         <= status;
			out_item.started_total  <= started_cnt_d;
			out_item.finished_total <= finished_cnt_d;
			out_item.flushed_total  <= flushed_cnt_d;
		end else if (cmd.emit_rec) begin
			out_item.has_record     <= 1'b1;
			out_item.record_out     <= reorder_q ? 32'(rec_rdata_q[KEEP-1:0])
				: 32'(fifo_rdata_q[KEEP-1:0]);
			out_item.record_id      <= reorder_q ? base_q : fifo_rdata_q[ENT_W-1:HANDLE_BITS];
			out_item.last           <= cmd.last;
			out_item.status         <= ST_OK;
			out_item.started_total  <= started_cnt_d;
			out_item.finished_total <= finished_cnt_d;
			out_item.flushed_total  <= flushed_cnt_d;
		end else if (cmd.emit_empty) begin
			out_item.has_record     <= 1'b0;
			out_item.record_out     <= '0;
			out_item.record_id      <= '0;
			out_item.last           <= 1'b1;
			out_item.status         <= ST_OK;
			out_item.started_total  <= started_cnt_d;
			out_item.finished_total <= finished_cnt_d;
			out_item.flushed_total  <= flushed_cnt_d;
		end
	end

endmodule

[hdl/in_order_output_reorder_buffer.sv]
// In-order reorder buffer: begin, finish and flush requests over a ring window of
// WINDOW_DEPTH slots, releasing finished records in read-id order, or in arrival
// order through a FIFO of FIFO_DEPTH entries when reordering is disabled. A begin,
// a finish or an unused operation code gives one result in the next cycle; a new
// request is taken in the cycle that the previous result is taken. A flush first
// walks the finished marks from the window base, one slot per cycle, over up to
// WINDOW_DEPTH slots (passing at once when forced or in FIFO mode), then releases
// up to 32 records at one per cycle while the receiver takes them, the record store
// and FIFO being read one entry ahead; no new request is taken until its last result
// is loaded. No memory needs clearing after reset.
module in_order_output_reorder_buffer
	import iorob_pkg::*;
#(
	parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
	parameter int FIFO_DEPTH   = FIFO_DEPTH_DEF,
	parameter int HANDLE_BITS  = HANDLE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic                  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	iorob_req_if.sink             request,
	iorob_rsp_if.source           result
);

	cmd_t cmd;
	sts_t st;

	// Sequence requests
	iorob_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (request.valid),
		.in_op     (request.payload.operation),
		.in_ready  (request.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.st        (st),
		.cmd       (cmd)
	);

	// Hold window, FIFO and result register
	iorob_dp #(
		.WINDOW_DEPTH (WINDOW_DEPTH),
		.FIFO_DEPTH   (FIFO_DEPTH),
		.HANDLE_BITS  (HANDLE_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_item   (request.payload),
		.cmd       (cmd),
		.st        (st),
		.out_item  (result.payload)
	);

	`include "in_order_output_reorder_buffer_assert.svh"

	`IOROB_ASSERT_IMPLY(a_release_needs_entry, cmd.emit_rec, st.avail, "release without a finished entry")
	`IOROB_ASSERT_IMPLY(a_one_load, 1'b1, $onehot0({cmd.do_op, cmd.emit_rec, cmd.emit_empty}), "two result loads at once")
	`IOROB_ASSERT_IMPLY(a_no_request_mid_run, result.valid && !result.payload.last, !request.ready, "request taken inside a release run")
	`IOROB_ASSERT_NEXT(a_flush_loads_nothing, cmd.flush_start, !result.valid || !result.payload.has_record || result.payload.last || !$past(result.ready), "flush start over an open run")

endmodule

[tb/in_order_output_reorder_buffer_tb.sv]
// Testbench of the in-order reorder buffer: table and random requests checked against a predictor.
`timescale 1ns / 1ps

module in_order_output_reorder_buffer_tb;
	import iorob_pkg::*;

	localparam int WIN          = WINDOW_DEPTH_DEF;
	localparam int FDEPTH       = FIFO_DEPTH_DEF;
	localparam int LIMIT_CYCLES = 500000;
	localparam int HOLD_CYCLES  = 300;
	localparam int TAIL_CYCLES  = 2 * WIN + 8;
	localparam logic [1:0] OP_SPARE = 2'd3;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	iorob_req_if req_ch ();
	iorob_rsp_if rsp_ch ();

	in_order_output_reorder_buffer DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.request   (req_ch),
		.result    (rsp_ch)
	);

	// Clock
	initial clk = 1'b0;
	always #2 clk = ~clk;

	// Predictor state: window, pass-through FIFO, counters, registers
	logic [31:0] win_base;
	int unsigned win_head;
	bit          began_mark [WIN];
	bit          done_mark [WIN];
	logic [31:0] rec_store [WIN];
	logic [31:0] fifo_handle [FDEPTH];
	logic [31:0] fifo_id [FDEPTH];
	int unsigned fifo_rd;
	int unsigned fifo_cnt;
	logic [31:0] n_started;
	logic [31:0] n_finished;
	logic [31:0] n_flushed;
	bit          cfg_reorder;
	logic [5:0]  cfg_thr;

	rsp_item_t due_results [$];

	// Run bookkeeping
	int errors;
	int items_sent;
	int results_seen;
	int records_seen;
	int settings_used;
	int cycle_cnt;
	int snd_idle;
	int rcv_idle;
	bit pressure_go;
	logic rcv_hold;
	int hold_cycles;

	typedef struct {
		req_item_t rq;
		bit        typed;
		rsp_item_t want;
	} dir_row_t;

	localparam int DIR_N = 18;
	dir_row_t dir_tab [DIR_N];

	function automatic req_item_t req_of(logic [1:0] op, logic [31:0] id, logic [31:0] h,
			logic forced);
		req_item_t r;
		r.operation     = op;
		r.read_id       = id;
		r.record_handle = h;
		r.force_flush   = forced;
		return r;
	endfunction

	function automatic rsp_item_t res_of(logic has, logic [31:0] h, logic [31:0] id,
			logic last, logic [1:0] st, logic [31:0] s, logic [31:0] f, logic [31:0] fl);
		rsp_item_t r;
		r.has_record     = has;
		r.record_out     = h;
		r.record_id      = id;
		r.last           = last;
		r.status         = st;
		r.started_total  = s;
		r.finished_total = f;
		r.flushed_total  = fl;
		return r;
	endfunction

	function automatic string show(rsp_item_t r);
		return $sformatf("has=%0d rec=%h id=%h last=%0d st=%0d totals=%0d/%0d/%0d",
			r.has_record, r.record_out, r.record_id, r.last, r.status,
			r.started_total, r.finished_total, r.flushed_total);
	endfunction

	// Queue one expected result with the counters as they stand now
	function automatic void owe(logic has, logic [31:0] h, logic [31:0] id, logic last,
			logic [1:0] st);
		due_results.push_back(res_of(has, h, id, last, st, n_started, n_finished, n_flushed));
	endfunction

	function automatic void clear_prediction();
		win_base    = '0;
		win_head    = 0;
		fifo_rd     = 0;
		fifo_cnt    = 0;
		n_started   = '0;
		n_finished  = '0;
		n_flushed   = '0;
		cfg_reorder = REORDER_RESET;
		cfg_thr     = THR_RESET;
		for (int i = 0; i < WIN; i++) begin
			began_mark[i] = 1'b0;
			done_mark[i]  = 1'b0;
			rec_store[i]  = '0;
		end
	endfunction

	// Release the finished run, or drain the FIFO, one result per record, else one empty result
	function automatic void predict_flush(logic forced);
		int run;
		int n_out;
		int s;
		n_out = 0;
		if (!cfg_reorder) begin
			n_out = (fifo_cnt < MAX_OUT) ? fifo_cnt : MAX_OUT;
			for (int k = 0; k < n_out; k++) begin
				s = fifo_rd;
				fifo_rd = (fifo_rd + 1) % FDEPTH;
				fifo_cnt--;
				n_flushed++;
				owe(1'b1, fifo_handle[s], fifo_id[s], k == n_out - 1, ST_OK);
			end
		end else begin
			run = 0;
			while (run < WIN && done_mark[(win_head + run) % WIN])
				run++;
			if (forced || run >= cfg_thr)
				n_out = (run < MAX_OUT) ? run : MAX_OUT;
			for (int k = 0; k < n_out; k++) begin
				s = win_head;
				began_mark[s] = 1'b0;
				done_mark[s]  = 1'b0;
				win_head = (win_head + 1) % WIN;
				n_flushed++;
				owe(1'b1, rec_store[s], win_base, k == n_out - 1, ST_OK);
				win_base++;
			end
		end
		if (n_out == 0)
			owe(1'b0, '0, '0, 1'b1, ST_OK);
	endfunction

	// Work out the results of one accepted request
	function automatic void apply_request(req_item_t r);
		logic [31:0] off;
		logic [1:0]  st;
		int s;
		off = r.read_id - win_base;
		st  = ST_OK;
		s   = (off < WIN) ? (win_head + int'(off)) % WIN : 0;
		if (r.operation == OP_FLUSH) begin
			predict_flush(r.force_flush);
			return;
		end
		if (r.operation == OP_BEGIN) begin
			if (!cfg_reorder) begin
				n_started++;
			end else if (off >= WIN) begin
				st = ST_RANGE;
			end else begin
				began_mark[s] = 1'b1;
				done_mark[s]  = 1'b0;
				n_started++;
			end
		end else if (r.operation == OP_FINISH) begin
			if (!cfg_reorder) begin
				if (fifo_cnt >= FDEPTH) begin
					st = ST_FULL;
				end else begin
					fifo_handle[(fifo_rd + fifo_cnt) % FDEPTH] = r.record_handle;
					fifo_id[(fifo_rd + fifo_cnt) % FDEPTH]     = r.read_id;
					fifo_cnt++;
					n_finished++;
				end
			end else if (off >= WIN) begin
				st = ST_RANGE;
			end else if (!began_mark[s] || done_mark[s]) begin
				st = ST_DUP;
			end else begin
				rec_store[s] = r.record_handle;
				done_mark[s] = 1'b1;
				n_finished++;
			end
		end
		owe(1'b0, '0, '0, 1'b1, st);
	endfunction

	function automatic void mix(ref int a[]);
		int j;
		int t;
		for (int i = a.size() - 1; i > 0; i--) begin
			j    = $urandom_range(i, 0);
			t    = a[i];
			a[i] = a[j];
			a[j] = t;
		end
	endfunction

	// Offer one request, idling at random first; predict once it is taken
	task automatic send_req(input req_item_t rq, input bit typed = 1'b0,
			input rsp_item_t want = '0);
		@(negedge clk);
		while ($urandom_range(99, 0) < snd_idle) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid   <= 1'b1;
		req_ch.payload <= rq;
		do
			@(posedge clk);
		while (!req_ch.ready);
		apply_request(rq);
		if (typed) begin
			void'(due_results.pop_back());
			due_results.push_back(want);
		end
		items_sent++;
	endtask

	task automatic send_noise();
		logic [31:0] id;
		id = ($urandom_range(1, 0) != 0) ? win_base + $urandom_range(WIN + 8, 0) : $urandom;
		send_req(req_of(2'($urandom_range(3, 0)), id, $urandom, 1'($urandom_range(1, 0))));
	endtask

	// Begin a run of ids from the base, finish them out of order, then flush
	task automatic run_batch(input int n);
		int order[];
		logic [31:0] b;
		b = win_base;
		order = new[n];
		for (int k = 0; k < n; k++)
			order[k] = k;
		mix(order);
		for (int k = 0; k < n; k++) begin
			send_req(req_of(OP_BEGIN, b + order[k], $urandom, 1'($urandom_range(1, 0))));
			if ($urandom_range(9, 0) == 0)
				send_noise();
		end
		mix(order);
		for (int k = 0; k < n; k++) begin
			send_req(req_of(OP_FINISH, b + order[k], $urandom, 1'($urandom_range(1, 0))));
			if ($urandom_range(9, 0) == 0)
				send_noise();
		end
		send_req(req_of(OP_FLUSH, $urandom, $urandom, $urandom_range(3, 0) != 0));
	endtask

	task automatic reorder_phase(input int n, input bit full_window);
		int target;
		target = items_sent + n;
		if (full_window)
			run_batch(WIN);
		while (items_sent < target) begin
			if ($urandom_range(4, 0) == 0)
				send_noise();
			else if ($urandom_range(6, 0) == 0)
				run_batch($urandom_range(WIN, 9));
			else
				run_batch($urandom_range(8, 1));
		end
	endtask

	task automatic fifo_phase(input int n, input bit fill);
		int target;
		int pick;
		target = items_sent + n;
		// Overfill the FIFO, then drain it
		if (fill) begin
			for (int k = 0; k < FDEPTH + 2; k++)
				send_req(req_of(OP_FINISH, $urandom, $urandom, 1'($urandom_range(1, 0))));
			send_req(req_of(OP_FLUSH, $urandom, $urandom, 1'b0));
			send_req(req_of(OP_FLUSH, $urandom, $urandom, 1'b1));
		end
		while (items_sent < target) begin
			pick = $urandom_range(99, 0);
			if (pick < 60)
				send_req(req_of(OP_FINISH, $urandom, $urandom, 1'($urandom_range(1, 0))));
			else if (pick < 75)
				send_req(req_of(OP_BEGIN, $urandom, $urandom, 1'($urandom_range(1, 0))));
			else if (pick < 88)
				send_req(req_of(OP_FLUSH, $urandom, $urandom, 1'($urandom_range(1, 0))));
			else
				send_noise();
		end
	endtask

	// Drop valid and wait until every expected result has come
	task automatic settle();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (due_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	task automatic set_reg(input logic idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_REORDER_ENABLE)
			cfg_reorder = val[0];
		else
			cfg_thr = val[5:0];
		settings_used++;
	endtask

	// Receiver: stall at random, or hold off completely under pressure
	always @(negedge clk) begin
		rsp_ch.ready <= !rcv_hold && ($urandom_range(99, 0) >= rcv_idle);
	end

	// Count out the long hold-off once asked for
	always @(negedge clk) begin
		if (rcv_hold) begin
			if (hold_cycles == HOLD_CYCLES - 1) begin
				rcv_hold    <= 1'b0;
				pressure_go = 1'b0;
			end
			hold_cycles <= hold_cycles + 1;
		end else if (pressure_go) begin
			rcv_hold    <= 1'b1;
			hold_cycles <= 0;
		end
	end

	// Check each taken result against the oldest expectation
	rsp_item_t got;
	rsp_item_t want;
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			got = rsp_ch.payload;
			results_seen++;
			if (got.has_record === 1'b1)
				records_seen++;
			if (due_results.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result: %s", show(got));
			end else begin
				want = due_results.pop_front();
				if (got.has_record !== want.has_record || got.record_out !== want.record_out ||
						got.record_id !== want.record_id || got.last !== want.last ||
						got.status !== want.status ||
						got.started_total !== want.started_total ||
						got.finished_total !== want.finished_total ||
						got.flushed_total !== want.flushed_total) begin
					errors++;
					if (errors <= 10) begin
						$display("result %0d differs", results_seen);
						$display("  expected %s", show(want));
						$display("  actual   %s", show(got));
					end
				end
			end
		end
	end

	// Abort a run that hangs
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
				due_results.size());
			$display("in_order_output_reorder_buffer: mismatch");
			$finish;
		end
	end

	initial begin
		// Table of directed requests; typed results follow at a glance from reset
		dir_tab[0]  = '{req_of(OP_BEGIN, 32'd0, 32'd0, 1'b0), 1'b1,
			res_of(1'b0, 0, 0, 1'b1, ST_OK, 1, 0, 0)};
		dir_tab[1]  = '{req_of(OP_BEGIN, 32'd32, 32'hFFFF_FFFF, 1'b1), 1'b1,
			res_of(1'b0, 0, 0, 1'b1, ST_RANGE, 1, 0, 0)};
		dir_tab[2]  = '{req_of(OP_BEGIN, 32'hFFFF_FFFF, 32'd0, 1'b0), 1'b1,
			res_of(1'b0, 0, 0, 1'b1, ST_RANGE, 1, 0, 0)};
		dir_tab[3]  = '{req_of(OP_FINISH, 32'd5, 32'h1234_5678, 1'b0), 1'b1,
			res_of(1'b0, 0, 0, 1'b1, ST_DUP, 1, 0, 0)};
		dir_tab[4]  = '{req_of(OP_FINISH, 32'd0, 32'hFFFF_FFFF, 1'b0), 1'b1,
			res_of(1'b0, 0, 0, 1'b1, ST_OK, 1, 1, 0)};
		dir_tab[5]  = '{req_of(OP_FINISH, 32'd0, 32'h0BAD_0BAD, 1'b1), 1'b1,
			res_of(1'b0, 0, 0, 1'b1, ST_DUP, 1, 1, 0)};
		dir_tab[6]  = '{req_of(OP_FLUSH, 32'd0, 32'd0, 1'b0), 1'b1,
			res_of(1'b0, 0, 0, 1'b1, ST_OK, 1, 1, 0)};
		dir_tab[7]  = '{req_of(OP_SPARE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1), 1'b1,
			res_of(1'b0, 0, 0, 1'b1, ST_OK, 1, 1, 0)};
		dir_tab[8]  = '{req_of(OP_BEGIN, 32'd1, 32'd0, 1'b0), 1'b1,
			res_of(1'b0, 0, 0, 1'b1, ST_OK, 2, 1, 0)};
		dir_tab[9]  = '{req_of(OP_BEGIN, 32'd31, 32'd0, 1'b0), 1'b1,
			res_of(1'b0, 0, 0, 1'b1, ST_OK, 3, 1, 0)};
		dir_tab[10] = '{req_of(OP_FINISH, 32'd31, 32'd0, 1'b0), 1'b1,
			res_of(1'b0, 0, 0, 1'b1, ST_OK, 3, 2, 0)};
		dir_tab[11] = '{req_of(OP_BEGIN, 32'd1, 32'd0, 1'b0), 1'b0, '0};
		dir_tab[12] = '{req_of(OP_FINISH, 32'd1, 32'hA5A5_A5A5, 1'b0), 1'b0, '0};
		dir_tab[13] = '{req_of(OP_FLUSH, 32'd0, 32'd0, 1'b1), 1'b0, '0};
		dir_tab[14] = '{req_of(OP_FLUSH, 32'd0, 32'd0, 1'b1), 1'b1,
			res_of(1'b0, 0, 0, 1'b1, ST_OK, 4, 3, 2)};
		dir_tab[15] = '{req_of(OP_BEGIN, 32'd0, 32'd0, 1'b0), 1'b1,
			res_of(1'b0, 0, 0, 1'b1, ST_RANGE, 4, 3, 2)};
		dir_tab[16] = '{req_of(OP_FINISH, 32'd31, 32'd7, 1'b0), 1'b1,
			res_of(1'b0, 0, 0, 1'b1, ST_DUP, 4, 3, 2)};
		dir_tab[17] = '{req_of(OP_BEGIN, 32'd33, 32'd0, 1'b0), 1'b0, '0};

		// Drive every input to a known value, then reset
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_index      = CFG_REORDER_ENABLE;
		cfg_data       = '0;
		req_ch.valid   = 1'b0;
		req_ch.payload = '0;
		rsp_ch.ready   = 1'b0;
		rcv_hold       = 1'b0;
		hold_cycles    = 0;
		pressure_go    = 1'b0;
		errors         = 0;
		items_sent     = 0;
		results_seen   = 0;
		records_seen   = 0;
		settings_used  = 0;
		cycle_cnt      = 0;
		snd_idle       = 11;
		rcv_idle       = 73;
		clear_prediction();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed requests at the reset settings
		for (int i = 0; i < DIR_N; i++)
			send_req(dir_tab[i].rq, dir_tab[i].typed, dir_tab[i].want);

		// Reordering at thresholds of 1 and 32
		settle();
		set_reg(CFG_FLUSH_THRESHOLD, 6'd1);
		reorder_phase(55, 1'b0);
		settle();
		set_reg(CFG_FLUSH_THRESHOLD, 6'd32);
		reorder_phase(55, 1'b1);

		// Pass-through FIFO, then back to reordering with data still held
		snd_idle = 73;
		rcv_idle = 11;
		settle();
		set_reg(CFG_REORDER_ENABLE, 6'd0);
		set_reg(CFG_FLUSH_THRESHOLD, 6'd0);
		fifo_phase(60, 1'b1);
		settle();
		set_reg(CFG_REORDER_ENABLE, 6'd1);
		set_reg(CFG_FLUSH_THRESHOLD, 6'd63);
		reorder_phase(45, 1'b0);

		// No idling; a long receiver hold-off fills the block
		snd_idle = 0;
		rcv_idle = 0;
		settle();
		set_reg(CFG_REORDER_ENABLE, 6'd0);
		set_reg(CFG_FLUSH_THRESHOLD, 6'd20);
		fifo_phase(35, 1'b0);
		settle();
		set_reg(CFG_REORDER_ENABLE, 6'd1);
		set_reg(CFG_FLUSH_THRESHOLD, 6'd0);
		pressure_go = 1'b1;
		reorder_phase(35, 1'b0);

		settle();
		$display("covered %0d requests, %0d results, %0d released records",
			items_sent, results_seen, records_seen);
		$display("over %0d register writes in both modes, with a %0d-cycle receiver hold-off",
			settings_used, HOLD_CYCLES);
		if (errors == 0 && due_results.size() == 0) begin
			$display("in_order_output_reorder_buffer: match");
		end else begin
			$display("%0d mismatches, %0d results still expected", errors, due_results.size());
			$display("in_order_output_reorder_buffer: mismatch");
		end
		$finish;
	end

endmodule

[in_order_output_reorder_buffer.f]
+incdir+hdl
hdl/iorob_pkg.sv
hdl/iorob_req_if.sv
hdl/iorob_rsp_if.sv
hdl/iorob_ctrl.sv
hdl/iorob_dp.sv
hdl/in_order_output_reorder_buffer.sv
tb/in_order_output_reorder_buffer_tb.sv
